@@ src/swm_pkg.sv @@
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CFG_W        = 7;
  localparam int AGE_W        = $clog2(MAX_WINDOW + 1);
  localparam int POS_MOD      = 2 * MAX_WINDOW;
  localparam int POS_W        = $clog2(POS_MOD);
  localparam int CMP_W        = (CFG_W > AGE_W) ? CFG_W : AGE_W;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_sample;
  } swm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] window_max;
    logic                           short_sequence;
    logic                           sequence_end;
  } swm_out_t;

  // one deque candidate; age counts samples since it was taken in
  typedef struct packed {
    logic                           valid;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic [AGE_W-1:0]               age;
  } swm_entry_t;

  typedef struct packed {
    logic step;   // request accepted this cycle
    logic shift;  // front candidate retires, chain moves one toward the front
    logic clear;  // end of sequence, drop everything
  } swm_ctrl_t;

endpackage

`default_nettype wire

@@ src/swm_cell.sv @@
`default_nettype none

module swm_cell import swm_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  swm_entry_t                     right_i,
  input  logic                           left_keep_i,
  output swm_entry_t                     entry_o,
  output logic                           keep_o
);

  logic                           valid_q, valid_d;
  logic signed [SAMPLE_WIDTH-1:0] value_q, value_d;
  logic [AGE_W-1:0]               age_q, age_d;
  swm_entry_t                     cur;

  assign entry_o = '{valid: valid_q, value: value_q, age: age_q};

  // entry this cell sees after an optional retire of the front
  assign cur    = ctrl_i.shift ? right_i : entry_o;
  // equal values stay, only strictly smaller ones are dropped
  assign keep_o = cur.valid && !(cur.value < sample_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    age_d   = age_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (keep_o) begin
        valid_d = 1'b1;
        value_d = cur.value;
        age_d   = cur.age + AGE_W'(1);
      end else if (left_keep_i) begin
        // first free slot behind the survivors takes the new sample
        valid_d = 1'b1;
        value_d = sample_i;
        age_d   = AGE_W'(1);
      end else begin
        valid_d = 1'b0;
      end
    end else if (ctrl_i.shift) begin
      valid_d = cur.valid;
      value_d = cur.value;
      age_d   = cur.age;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

endmodule

`default_nettype wire

@@ src/swm_skid.sv @@
`default_nettype none

module swm_skid import swm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  input  swm_out_t res_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output swm_out_t out_res_o
);

  logic     out_valid_q, skid_valid_q;
  swm_out_t out_q, skid_q;
  logic     slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q  <= skid_valid_q || res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ src/sliding_window_maximum_unit.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------
// in       | in_valid_i / in_stall_o    | in_req_i  : sample, last_sample
// out      | out_valid_o / out_stall_i  | out_res_o : window_max,
//          |                            |             short_sequence, sequence_end
// cfg      | cfg_we_i                   | cfg_wdata_i : window_size
//
// One request per cycle while in_stall_o is low: every cell of the chain updates
// from its neighbor together; the result is registered in the output stage, or
// in the skid register while the output stalls. A window_size write starts a
// purge that retires one front candidate per cycle through cell 0, up to
// MAX_WINDOW of them; in_stall_o stays high until the front no longer retires.
// Reset: all candidates invalid, window_size = 3, output empty, no purge.
// Stalls: a two-deep output buffer lets one request be accepted while a result
// waits; in_stall_o rises once both slots hold results.
`default_nettype none

module sliding_window_maximum_unit import swm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  swm_in_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output swm_out_t         out_res_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  logic [CFG_W-1:0] win_cfg_q;
  logic [AGE_W-1:0] win_eff;
  logic             purge_q;
  logic [POS_W-1:0] pos_q;
  logic             filled_q;
  logic             filled_d;
  logic             in_accept;
  logic             retire;
  logic             skid_full;
  logic             res_valid;
  swm_out_t         res;
  swm_ctrl_t        ctrl;
  swm_entry_t       front;

  swm_entry_t       ent  [MAX_WINDOW];
  logic             keep [MAX_WINDOW];

  function automatic logic cfg_wdata_zero(input logic [CFG_W-1:0] v);
    return v == '0;
  endfunction

  // window size: zero behaves as one, saturate at the chain length
  always_comb begin
    if (cfg_wdata_zero(win_cfg_q)) begin
      win_eff = AGE_W'(1);
    end else if (CMP_W'(win_cfg_q) > CMP_W'(MAX_WINDOW)) begin
      win_eff = AGE_W'(MAX_WINDOW);
    end else begin
      win_eff = AGE_W'(win_cfg_q);
    end
  end

  assign in_stall_o = purge_q || skid_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // front candidate has aged out of the window for the next sample
  assign retire = ent[0].valid && (ent[0].age >= win_eff);

  assign ctrl.step  = in_accept;
  assign ctrl.shift = retire && (in_accept || purge_q);
  assign ctrl.clear = in_accept && in_req_i.last_sample;

  // cell chain: cell 0 is the deque front, candidates march toward it
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_entry_t right;
    logic       left_keep;

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = ent[i+1];
    end

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_keep = keep[i-1];
    end

    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sample_i    (in_req_i.sample),
      .right_i     (right),
      .left_keep_i (left_keep),
      .entry_o     (ent[i]),
      .keep_o      (keep[i])
    );
  end

  // new front: the front candidate after any retire if it survives, else the incoming sample
  assign front = ctrl.shift ? ent[1] : ent[0];

  assign filled_d = filled_q ||
                    (({1'b0, pos_q} + (POS_W + 1)'(1)) >= (POS_W + 1)'(win_eff));

  assign res_valid          = in_accept && (filled_d || in_req_i.last_sample);
  assign res.window_max     = keep[0] ? front.value : in_req_i.sample;
  assign res.short_sequence = !filled_d;
  assign res.sequence_end   = in_req_i.last_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= CFG_W'(3);
      purge_q   <= 1'b0;
      pos_q     <= '0;
      filled_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_cfg_q <= cfg_wdata_i;
        purge_q   <= 1'b1;
      end else if (purge_q && !retire) begin
        purge_q <= 1'b0;
      end
      if (in_accept) begin
        if (in_req_i.last_sample) begin
          pos_q    <= '0;
          filled_q <= 1'b0;
        end else begin
          pos_q    <= (pos_q == POS_W'(POS_MOD - 1)) ? '0 : pos_q + POS_W'(1);
          filled_q <= filled_d;
        end
      end
    end
  end

  swm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

`ifndef SYNTHESIS
  // candidates stay packed toward the front
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent[1].valid |-> ent[0].valid)
    else $error("deque hole behind front");

  // the last sample empties the chain
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_req_i.last_sample) |=> !ent[0].valid)
    else $error("chain not cleared after sequence end");

  // a short-sequence result only comes from the last sample
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.short_sequence) |-> out_res_o.sequence_end)
    else $error("short flag without sequence end");

  // no sample is taken while the chain is purging
  a_purge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (purge_q && retire) |=> !$past(in_accept))
    else $error("sample accepted during purge");
`endif

endmodule

`default_nettype wire
